// ===== src/dss_pkg.sv =====
// Shared types and constants for the SERVFAIL reply synthesiser.
package dss_pkg;

    // Query parsing phases
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LEN     = 3'd1,
        PH_BODY    = 3'd2,
        PH_POINTER = 3'd3,
        PH_TAIL    = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    // Header and name layout
    localparam logic [3:0] HDR_LAST   = 4'd11;   // final header byte index
    localparam logic [3:0] HDR_RD_IDX = 4'd2;    // flags high byte
    localparam logic [3:0] HDR_RC_IDX = 4'd3;    // flags low byte
    localparam logic [3:0] HDR_ZERO_IDX = 4'd6;  // counts after QDCOUNT start here, zeroed
    localparam logic [5:0] TAIL_LEN   = 6'd4;
    localparam logic [7:0] PTR_MASK   = 8'hc0;

    // Reply flags
    localparam logic [15:0] QR_BIT         = 16'h8000;
    localparam logic [15:0] RA_BIT         = 16'h0080;
    localparam logic [15:0] RCODE_SERVFAIL = 16'h0002;
    localparam logic [15:0] RD_BIT         = 16'h0100;
    localparam logic [15:0] FLAGS_BASE     = QR_BIT | RA_BIT | RCODE_SERVFAIL;

    // One queued request from front to back: a data byte, a verdict, or both
    typedef struct packed {
        logic       has_data;
        logic [7:0] data;
        logic       has_verdict;
        logic       no_reply;
    } t_entry;

endpackage

// ===== src/dss_front.sv =====
// Front end: walks the query byte by byte and classifies each into reply requests.
module dss_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_query_byte,
    input  logic            i_last,
    output dss_pkg::t_entry o_entry,
    output logic            o_entry_valid
);
    import dss_pkg::*;

    t_phase     r_phase, n_phase;
    logic [5:0] r_count, n_count;
    logic [3:0] r_hdr_idx, n_hdr_idx;
    logic       emit;
    logic [7:0] emit_byte;
    logic [5:0] count_dec;

    assign count_dec = r_count - 6'd1;

    // Phase update and byte rewriting
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_hdr_idx = r_hdr_idx;
        emit      = 1'b0;
        emit_byte = i_query_byte;
        case (r_phase)
            PH_HEADER: begin
                emit = 1'b1;
                if (r_hdr_idx == HDR_RD_IDX) begin
                    emit_byte = FLAGS_BASE[15:8] | (RD_BIT[15:8] & i_query_byte);
                end else if (r_hdr_idx == HDR_RC_IDX) begin
                    emit_byte = FLAGS_BASE[7:0];
                end else if (r_hdr_idx >= HDR_ZERO_IDX) begin
                    emit_byte = 8'h00;
                end
                if (r_hdr_idx >= HDR_LAST) begin
                    n_hdr_idx = 4'd0;
                    n_phase   = PH_LEN;
                end else begin
                    n_hdr_idx = r_hdr_idx + 4'd1;
                end
            end
            PH_LEN: begin
                if (i_query_byte == 8'h00) begin
                    emit    = 1'b1;
                    n_count = TAIL_LEN;
                    n_phase = PH_TAIL;
                end else if ((i_query_byte & PTR_MASK) == PTR_MASK) begin
                    emit    = 1'b1;
                    n_phase = PH_POINTER;
                end else if ((i_query_byte & PTR_MASK) != 8'h00) begin
                    n_phase = PH_ERROR;
                end else begin
                    emit    = 1'b1;
                    n_count = i_query_byte[5:0];
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                emit    = 1'b1;
                n_count = count_dec;
                if (count_dec == 6'd0) begin
                    n_phase = PH_LEN;
                end
            end
            PH_POINTER: begin
                emit    = 1'b1;
                n_count = TAIL_LEN;
                n_phase = PH_TAIL;
            end
            PH_TAIL: begin
                emit    = 1'b1;
                n_count = count_dec;
                if (count_dec == 6'd0) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        // Request towards the back end; verdict judged on the updated phase
        o_entry.has_data    = emit;
        o_entry.data        = emit_byte;
        o_entry.has_verdict = i_last;
        o_entry.no_reply    = (n_phase != PH_DONE);
        o_entry_valid       = i_accept & (emit | i_last);

        // End of message returns to the reset state
        if (i_last) begin
            n_phase   = PH_HEADER;
            n_count   = 6'd0;
            n_hdr_idx = 4'd0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_count   <= 6'd0;
            r_hdr_idx <= 4'd0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_hdr_idx <= n_hdr_idx;
        end
    end

endmodule

// ===== src/dss_queue.sv =====
// Short request queue between the front and back ends.
module dss_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dss_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output dss_pkg::t_entry o_head,
    output logic            o_empty
);
    import dss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry           r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_head  = r_slot[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_END) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_END) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/dss_back.sv =====
// Back end: turns queued requests into reply bytes and verdict items.
module dss_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dss_pkg::t_entry i_head,
    input  logic            i_head_empty,
    output logic            o_head_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [7:0]      o_reply_byte,
    output logic            o_verdict_item,
    output logic            o_no_reply
);
    import dss_pkg::*;

    logic r_data_sent;   // data half of the head request already delivered
    logic show_data;
    logic taken;

    assign show_data = i_head.has_data & ~r_data_sent;
    assign o_empty   = i_head_empty;
    assign taken     = i_pop & ~i_head_empty;

    // Head request leaves once its last item is taken
    assign o_head_pop = taken & ~(show_data & i_head.has_verdict);

    assign o_reply_byte   = show_data ? i_head.data : 8'h00;
    assign o_verdict_item = ~show_data;
    assign o_no_reply     = show_data ? 1'b0 : i_head.no_reply;

    // Split tracking for requests carrying a byte and a verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_sent <= 1'b0;
        end else if (taken) begin
            r_data_sent <= ~o_head_pop;
        end
    end

endmodule

// ===== src/dns_servfail_synthesizer.sv =====
// Top level of the streaming SERVFAIL reply synthesiser.
//
// Input channel: a query message, one byte per request on i_query_byte, with
// i_last on its final byte; a request is taken when i_push is high and o_full
// is low. Result channel: reply bytes, each with o_verdict_item low, then one
// verdict item per message (o_verdict_item high, o_no_reply set when the
// reply must be discarded). The oldest result sits on the ports while o_empty
// is low and is taken when i_pop is high.
// Results are registered in the request queue and leave it in order.
// Throughput: one byte per cycle while o_full is low; a final byte that yields
// both a data byte and a verdict gives two result items, the data byte first.
// The parser accepts bytes while the back end stalls until the QUEUE_DEPTH-entry
// request queue fills, then holds o_full high until the receiver pops.
// Reset (synchronous, i_rst_n low) empties the queue and returns the parser
// to the start of a header.
module dns_servfail_synthesizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_query_byte,
    input  logic       i_last,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_reply_byte,
    output logic       o_verdict_item,
    output logic       o_no_reply
);
    import dss_pkg::*;

    t_entry front_entry;
    logic   front_valid;
    t_entry head;
    logic   head_empty;
    logic   head_pop;
    logic   accept;

    assign accept = i_push & ~o_full;

    dss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_query_byte  (i_query_byte),
        .i_last        (i_last),
        .o_entry       (front_entry),
        .o_entry_valid (front_valid)
    );

    dss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_entry (front_entry),
        .o_full  (o_full),
        .i_pop   (head_pop),
        .o_head  (head),
        .o_empty (head_empty)
    );

    dss_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_head_empty   (head_empty),
        .o_head_pop     (head_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_reply_byte   (o_reply_byte),
        .o_verdict_item (o_verdict_item),
        .o_no_reply     (o_no_reply)
    );

endmodule
